@@ rtl/cmdchk_pkg.sv @@
// Shared types and constants of the command-stream register checker.
// Used by every module under rtl except cmdchk_ram; depends on nothing.
package cmdchk_pkg;

   localparam int COUNT_W = 20;
   localparam int EPOCH_W = 8;
   localparam int WORD_W  = 32;
   localparam int REG_W   = 15;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = 20'hFFFFF;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST  = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST   = 8'hFF;
   localparam logic [REG_W:0]     REG_PAST_END = 16'h8000;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_LOAD   = 2'd1;
   localparam logic [1:0] MODE_STREAM = 2'd2;

   localparam logic [1:0] PKT_TYPE0 = 2'd0;
   localparam logic [1:0] PKT_TYPE1 = 2'd1;
   localparam logic [1:0] PKT_TYPE3 = 2'd3;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_TYPE0,
      PHASE_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_CHECK,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [REG_W-1:0]   addr;
      logic [WORD_W-1:0]  word;
      logic               last;
      logic               discarded;
   } op_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                  input logic en);
      return (en && (v != COUNT_MAX)) ? v + 1'b1 : v;
   endfunction

endpackage

@@ rtl/cmdchk_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module cmdchk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cmdchk_queue.sv @@
// Short op queue between the parser front and the check back end.
// Depends on cmdchk_pkg for the op type.
module cmdchk_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cmdchk_pkg::op_type push_op,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output cmdchk_pkg::op_type head_op
);
   import cmdchk_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == COUNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_op   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> count_ff != COUNT_FULL)
      else $error("queue pushed while full");

endmodule

@@ rtl/cmdchk_front.sv @@
// Parser front: decodes items and command-stream packet headers into ops.
// Depends on cmdchk_pkg for phases, op codes and the op type.
module cmdchk_front #(
   parameter int NUM_REGS = 20483
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [1:0]                       req_mode,
   input  logic [cmdchk_pkg::REG_W-1:0]     req_reg_index,
   input  logic [cmdchk_pkg::WORD_W-1:0]    req_word,
   input  logic                             req_last,
   output logic                             push,
   output cmdchk_pkg::op_type               push_op
);
   import cmdchk_pkg::*;

   localparam logic [REG_W:0] NREGS = (REG_W + 1)'(NUM_REGS);

   phase_type          phase_ff, phase_in;
   logic [REG_W-1:0]   remaining_ff, remaining_in;
   logic [REG_W:0]     cur_reg_ff, cur_reg_in;
   logic               same_reg_ff, same_reg_in;
   logic               discarded_ff, discarded_in;

   logic [1:0]         hdr_type;
   logic [REG_W-1:0]   hdr_count;
   logic [REG_W-1:0]   rem_dec;
   logic               stream;
   logic               is_check;
   logic               load_ok;
   logic               disc_after;

   assign hdr_type  = req_word[31:30];
   assign hdr_count = {1'b0, req_word[29:16]} + 1'b1;
   assign rem_dec   = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;
   assign stream    = (req_mode == MODE_STREAM);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      cur_reg_in   = cur_reg_ff;
      same_reg_in  = same_reg_ff;
      discarded_in = discarded_ff;
      if (take && stream) begin
         if (req_last) begin
            phase_in     = PHASE_HEADER;
            remaining_in = '0;
            cur_reg_in   = '0;
            same_reg_in  = 1'b0;
            discarded_in = 1'b0;
         end else if (!discarded_ff) begin
            unique case (phase_ff)
               PHASE_TYPE0: begin
                  if (!same_reg_ff && (cur_reg_ff < REG_PAST_END)) begin
                     cur_reg_in = cur_reg_ff + 1'b1;
                  end
                  remaining_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = PHASE_HEADER;
                  end
               end
               PHASE_SKIP: begin
                  remaining_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = PHASE_HEADER;
                  end
               end
               PHASE_HEADER: begin
                  if (hdr_type == PKT_TYPE0) begin
                     cur_reg_in   = {1'b0, req_word[14:0]};
                     same_reg_in  = req_word[15];
                     remaining_in = hdr_count;
                     phase_in     = PHASE_TYPE0;
                  end else if (hdr_type == PKT_TYPE3) begin
                     remaining_in = hdr_count;
                     phase_in     = PHASE_SKIP;
                  end else if (hdr_type == PKT_TYPE1) begin
                     discarded_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = PHASE_HEADER;
               end
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      is_check   = !discarded_ff && (phase_ff == PHASE_TYPE0) && (cur_reg_ff < NREGS);
      load_ok    = ({1'b0, req_reg_index} < NREGS);
      disc_after = discarded_ff ||
                   ((phase_ff == PHASE_HEADER) && (hdr_type == PKT_TYPE1));
      push       = 1'b0;
      push_op.kind      = OP_END;
      push_op.addr      = cur_reg_ff[REG_W-1:0];
      push_op.word      = req_word;
      push_op.last      = 1'b0;
      push_op.discarded = disc_after;
      unique case (req_mode)
         MODE_CLEAR: begin
            push         = take;
            push_op.kind = OP_CLEAR;
         end
         MODE_LOAD: begin
            push         = take && load_ok;
            push_op.kind = OP_LOAD;
            push_op.addr = req_reg_index;
         end
         MODE_STREAM: begin
            push         = take && (is_check || req_last);
            push_op.kind = is_check ? OP_CHECK : OP_END;
            push_op.last = req_last;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HEADER;
         remaining_ff <= '0;
         cur_reg_ff   <= '0;
         same_reg_ff  <= 1'b0;
         discarded_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         cur_reg_ff   <= cur_reg_in;
         same_reg_ff  <= same_reg_in;
         discarded_ff <= discarded_in;
      end
   end

endmodule

@@ rtl/cmdchk_back.sv @@
// Check back end: shadow RAM with epoch tags, compare stage, counters and result register.
// Depends on cmdchk_pkg and cmdchk_ram.
module cmdchk_back #(
   parameter int NUM_REGS = 20483
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  cmdchk_pkg::op_type                q_op,
   output logic                              q_pop,
   output logic                              sweep_busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_mismatches,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_checked,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_unmapped
);
   import cmdchk_pkg::*;

   localparam int AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int RAM_W  = EPOCH_W + WORD_W;
   localparam logic [AW-1:0] ADDR_LAST = AW'(NUM_REGS - 1);

   // sweep and epoch
   logic                sweep_ff, sweep_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;

   // compare stage
   logic                b_valid_ff, b_valid_in;
   op_type              b_op_ff;
   logic [EPOCH_W-1:0]  b_epoch_ff;
   logic                b_ready, b_done, b_take;

   logic [COUNT_W-1:0]  mism_ff, mism_in, mism_new;
   logic [COUNT_W-1:0]  chk_ff, chk_in, chk_new;
   logic [COUNT_W-1:0]  unm_ff, unm_in, unm_new;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_mism_ff, rsp_chk_ff, rsp_unm_ff;
   logic                out_free, emit;

   // RAM ports
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr;
   logic [RAM_W-1:0]    wr_data, rd_data;
   logic                is_chk, mapped, differs;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b_done   = b_valid_ff && (!b_op_ff.last || out_free);
   assign b_ready  = !b_valid_ff || b_done;
   assign q_pop    = q_valid && !sweep_ff && b_ready;
   assign b_take   = q_pop && ((q_op.kind == OP_CHECK) || (q_op.kind == OP_END));
   assign emit     = b_done && b_op_ff.last;
   assign sweep_busy = sweep_ff;

   assign wr_en   = sweep_ff || (q_pop && (q_op.kind == OP_LOAD));
   assign wr_addr = sweep_ff ? sweep_addr_ff : q_op.addr[AW-1:0];
   assign wr_data = sweep_ff ? '0 : {epoch_ff, q_op.word};
   assign rd_en   = q_pop && (q_op.kind == OP_CHECK);

   cmdchk_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_REGS)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_op.addr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      epoch_in      = epoch_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == ADDR_LAST) begin
            sweep_in      = 1'b0;
            sweep_addr_in = '0;
         end
      end
      // a map clear retires the epoch; on wrap, wipe every tag first
      if (q_pop && (q_op.kind == OP_CLEAR)) begin
         if (epoch_ff == EPOCH_LAST) begin
            epoch_in = EPOCH_FIRST;
            sweep_in = 1'b1;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   // compare against the registered shadow entry read when the op entered this stage
   always_comb begin
      is_chk   = b_valid_ff && (b_op_ff.kind == OP_CHECK);
      mapped   = (rd_data[RAM_W-1:WORD_W] == b_epoch_ff);
      differs  = (rd_data[WORD_W-1:0] != b_op_ff.word);
      chk_new  = sat_inc(chk_ff, is_chk && mapped);
      mism_new = sat_inc(mism_ff, is_chk && mapped && differs);
      unm_new  = sat_inc(unm_ff, is_chk && !mapped);

      mism_in = mism_ff;
      chk_in  = chk_ff;
      unm_in  = unm_ff;
      if (b_done) begin
         mism_in = b_op_ff.last ? '0 : mism_new;
         chk_in  = b_op_ff.last ? '0 : chk_new;
         unm_in  = b_op_ff.last ? '0 : unm_new;
      end

      if (b_take) begin
         b_valid_in = 1'b1;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         epoch_ff      <= EPOCH_FIRST;
         b_valid_ff    <= 1'b0;
         mism_ff       <= '0;
         chk_ff        <= '0;
         unm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff      <= epoch_in;
         b_valid_ff    <= b_valid_in;
         mism_ff       <= mism_in;
         chk_ff        <= chk_in;
         unm_ff        <= unm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take) begin
         b_op_ff    <= q_op;
         b_epoch_ff <= epoch_ff;
      end
      if (emit) begin
         rsp_status_ff <= b_op_ff.discarded;
         rsp_mism_ff   <= b_op_ff.discarded ? '0 : mism_new;
         rsp_chk_ff    <= chk_new;
         rsp_unm_ff    <= unm_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_mismatches = rsp_mism_ff;
   assign rsp_checked    = rsp_chk_ff;
   assign rsp_unmapped   = rsp_unm_ff;

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !q_pop)
      else $error("op taken during tag sweep");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_done) |=> (b_valid_ff && $stable(b_op_ff) && !$past(rd_en)))
      else $error("compare stage lost its op or read data");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("epoch reached the never-mapped tag");

   a_emit_on_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrote a pending result");

endmodule

@@ rtl/command_stream_register_checker.sv @@
// Top level of the command-stream register checker.
// Depends on cmdchk_pkg, cmdchk_front, cmdchk_queue and cmdchk_back.

// The block takes one item per clock while req_stall is low; map clears, shadow
// loads and command-stream dwords are all limited by the single access per cycle
// that the shadow RAM gets from the back end. The front parses packet headers and
// hands clears, loads and register writes to a short queue; the back reads the
// shadow, compares the registered entry and builds the counts, so a result shows
// on rsp_ once the dword marked last has passed the queue, the compare stage and the
// result register. Map clears bump an 8-bit epoch tag kept with every shadow entry
// instead of touching the RAM. After reset, and after every 255th map clear, the
// back end sweeps all NUM_REGS tags and req_stall stays high until that sweep ends.
module command_stream_register_checker #(
   parameter int NUM_REGS    = 20483,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [cmdchk_pkg::REG_W-1:0]      req_reg_index,
   input  logic [cmdchk_pkg::WORD_W-1:0]     req_word,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_mismatches,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_checked,
   output logic [cmdchk_pkg::COUNT_W-1:0]    rsp_unmapped
);
   import cmdchk_pkg::*;

   logic    take;
   logic    push;
   op_type  push_op;
   logic    q_full;
   logic    q_valid;
   op_type  head_op;
   logic    q_pop;
   logic    sweep_busy;

   assign req_stall = q_full || sweep_busy;
   assign take      = req_valid && !req_stall;

   cmdchk_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .req_mode      (req_mode),
      .req_reg_index (req_reg_index),
      .req_word      (req_word),
      .req_last      (req_last),
      .push          (push),
      .push_op       (push_op)
   );

   cmdchk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_op   (head_op)
   );

   cmdchk_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_op           (head_op),
      .q_pop          (q_pop),
      .sweep_busy     (sweep_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_mismatches (rsp_mismatches),
      .rsp_checked    (rsp_checked),
      .rsp_unmapped   (rsp_unmapped)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("op pushed into a full queue");

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy |-> !take)
      else $error("item taken during tag sweep");

   a_push_needs_take: assert property (@(posedge clock) disable iff (reset)
      push |-> take)
      else $error("op pushed without an accepted item");

endmodule
